/* rtl/bbid_pkg.sv */
// ----------------------------------------------------------------------------
// Bintree image decoder package
// Shared constants, register indexes, decode modes and the fill word layout.
// ----------------------------------------------------------------------------
package bbid_pkg;

   // default sizes handed to the top level
   localparam int MAX_TILE_LOG2_DEF = 6;
   localparam int STACK_DEPTH_DEF   = 12;

   // code stream is byte packed
   localparam int BYTE_BITS = 8;
   localparam int BIT_POS_W = $clog2(BYTE_BITS);

   // port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int TILE_LOG2_W = 3;
   localparam int COORD_W     = 6;
   localparam int LOG2_W      = 3;
   localparam int PIXEL_W     = 8;

   // result queue
   localparam int RSP_QUEUE_DEPTH = 4;

   // register reset values
   localparam logic [TILE_LOG2_W-1:0] TILE_LOG2_RST  = 3'd3;
   localparam logic                   SQUARE_CUT_RST = 1'b0;
   localparam logic [PIXEL_W-1:0]     LOW_VALUE_RST  = 8'd0;
   localparam logic [PIXEL_W-1:0]     HIGH_VALUE_RST = 8'd255;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TILE_HEIGHT_LOG2    = 3'd0,
      REG_TILE_WIDTH_LOG2     = 3'd1,
      REG_SQUARE_CUT_VERTICAL = 3'd2,
      REG_LOW_VALUE           = 3'd3,
      REG_HIGH_VALUE          = 3'd4
   } reg_index_type;

   // what the next code bit means
   typedef enum logic [1:0] {
      MODE_NODE   = 2'd0,
      MODE_COLOUR = 2'd1,
      MODE_FLAG   = 2'd2,
      MODE_SKIP   = 2'd3
   } mode_type;

   // one fill command
   typedef struct packed {
      logic [COORD_W-1:0] fill_row;
      logic [COORD_W-1:0] fill_col;
      logic [LOG2_W-1:0]  fill_height_log2;
      logic [LOG2_W-1:0]  fill_width_log2;
      logic [PIXEL_W-1:0] pixel_value;
      logic               tile_done;
      logic               last_of_run;
   } result_type;

endpackage

/* rtl/bintree_binary_image_decoder.sv */
// ----------------------------------------------------------------------------
// Bintree binary image decoder
// Decodes a bintree code of one binary-image tile, one code bit per word, into
// fill commands for the uniform regions it describes.
// ----------------------------------------------------------------------------
// One code bit is taken per cycle. Each bit is decoded in a single pass between
// the input register and a four-entry result queue. A bit that ends a uniform
// first half whose sibling is a single pixel yields two fill words, and since
// the result side moves one word per cycle while rsp_ready is high, such bits
// cost two words of output bandwidth; the input stalls only when the queue
// holds more than two words. Walking back up the split tree is a priority pick
// over the pending-sibling stack, so any number of completed levels unwind
// within the same cycle. Tile size is taken at the first bit of each tile; the
// other registers apply live. Padding bits after a tile up to the next byte
// boundary produce no fill. A split that would overflow the stack drops the
// rest of the tile silently. Configuration is to be written through csr_ only
// while the decoder is idle (the user's duty, unchecked); csr_ is always ready.
module bintree_binary_image_decoder #(
   parameter int MAX_TILE_LOG2 = bbid_pkg::MAX_TILE_LOG2_DEF,
   parameter int STACK_DEPTH   = bbid_pkg::STACK_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // code bit input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_code_bit,
   // fill command output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bbid_pkg::COORD_W-1:0]       rsp_fill_row,
   output logic [bbid_pkg::COORD_W-1:0]       rsp_fill_col,
   output logic [bbid_pkg::LOG2_W-1:0]        rsp_fill_height_log2,
   output logic [bbid_pkg::LOG2_W-1:0]        rsp_fill_width_log2,
   output logic [bbid_pkg::PIXEL_W-1:0]       rsp_pixel_value,
   output logic                               rsp_tile_done,
   output logic                               rsp_last_of_run,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bbid_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bbid_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // coordinate and log2 widths inside the tile
   localparam int RW  = MAX_TILE_LOG2;
   localparam int LW  = $clog2(MAX_TILE_LOG2 + 1);
   localparam int IW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int QD  = bbid_pkg::RSP_QUEUE_DEPTH;
   localparam int QPW = $clog2(QD);
   localparam int QCW = $clog2(QD + 1);
   localparam logic [LW+bbid_pkg::TILE_LOG2_W-1:0] MAX_EXT =
      (LW + bbid_pkg::TILE_LOG2_W)'(MAX_TILE_LOG2);

   typedef struct packed {
      logic [RW-1:0] row;
      logic [RW-1:0] col;
      logic [LW-1:0] hl;
      logic [LW-1:0] wl;
   } region_type;

   // region with no extent left in either direction
   function automatic logic is_unit(input region_type r);
      return (r.hl == '0) && (r.wl == '0);
   endfunction

   // saturate a tile size register to the largest supported tile
   function automatic logic [LW-1:0] sat_log2(input logic [bbid_pkg::TILE_LOG2_W-1:0] v);
      logic [LW+bbid_pkg::TILE_LOG2_W-1:0] v_ext;
      v_ext = {{LW{1'b0}}, v};
      if (v_ext > MAX_EXT) begin
         return MAX_EXT[LW-1:0];
      end
      return v_ext[LW-1:0];
   endfunction

   // build a fill word from a region and a colour bit
   function automatic bbid_pkg::result_type make_fill(
      input region_type                   r,
      input logic                         colour,
      input logic [bbid_pkg::PIXEL_W-1:0] low,
      input logic [bbid_pkg::PIXEL_W-1:0] high
   );
      logic [RW+bbid_pkg::COORD_W-1:0] row_ext;
      logic [RW+bbid_pkg::COORD_W-1:0] col_ext;
      logic [LW+bbid_pkg::LOG2_W-1:0]  hl_ext;
      logic [LW+bbid_pkg::LOG2_W-1:0]  wl_ext;
      bbid_pkg::result_type            f;
      row_ext = {{bbid_pkg::COORD_W{1'b0}}, r.row};
      col_ext = {{bbid_pkg::COORD_W{1'b0}}, r.col};
      hl_ext  = {{bbid_pkg::LOG2_W{1'b0}}, r.hl};
      wl_ext  = {{bbid_pkg::LOG2_W{1'b0}}, r.wl};
      f.fill_row         = row_ext[bbid_pkg::COORD_W-1:0];
      f.fill_col         = col_ext[bbid_pkg::COORD_W-1:0];
      f.fill_height_log2 = hl_ext[bbid_pkg::LOG2_W-1:0];
      f.fill_width_log2  = wl_ext[bbid_pkg::LOG2_W-1:0];
      f.pixel_value      = colour ? low : high;
      f.tile_done        = 1'b0;
      f.last_of_run      = 1'b0;
      return f;
   endfunction

   // configuration registers
   logic [bbid_pkg::TILE_LOG2_W-1:0] tile_h_ff;
   logic [bbid_pkg::TILE_LOG2_W-1:0] tile_w_ff;
   logic                             cut_v_ff;
   logic [bbid_pkg::PIXEL_W-1:0]     low_ff;
   logic [bbid_pkg::PIXEL_W-1:0]     high_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_bit_ff;

   // decoder state
   bbid_pkg::mode_type               mode_ff, mode_in;
   region_type                       cur_ff, cur_in;
   logic                             first_ff, first_in;
   logic [SPW-1:0]                   sp_ff, sp_in;
   logic [bbid_pkg::BIT_POS_W-1:0]   bib_ff, bib_in;
   region_type                       top_sib_ff, top_sib_in;
   logic                             colour_ff, colour_in;

   // pending sibling stack
   region_type                       stk_sib_ff [STACK_DEPTH];
   logic                             stk_pf_ff  [STACK_DEPTH];
   logic                             push_en;
   logic [IW-1:0]                    push_idx;

   // result queue
   bbid_pkg::result_type             q_ff [QD];
   logic [QPW-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]                   count_ff, count_in;
   logic                             rsp_pop;
   bbid_pkg::result_type             rsp_word;

   // decode signals
   logic                             step;
   logic [bbid_pkg::BIT_POS_W-1:0]   bib_next;
   region_type                       root;
   region_type                       work;
   region_type                       split_a, split_b;
   logic                             cut_vert;
   logic                             found;
   logic [SPW-1:0]                   tgt_m;
   logic [SPW-1:0]                   tgt_dec;
   logic [IW-1:0]                    tgt_idx;
   logic                             fill_first;
   logic                             fill_c;
   logic                             fin_has_c;
   logic                             do_split;
   logic                             to_colour;
   logic                             to_sib;
   logic                             second;
   logic                             walk;
   logic                             tile_end;
   logic                             overflow;
   logic [1:0]                       n_res;
   bbid_pkg::result_type             res0, res1;

   // ------------------------------------------------------------------------
   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_h_ff <= bbid_pkg::TILE_LOG2_RST;
         tile_w_ff <= bbid_pkg::TILE_LOG2_RST;
         cut_v_ff  <= bbid_pkg::SQUARE_CUT_RST;
         low_ff    <= bbid_pkg::LOW_VALUE_RST;
         high_ff   <= bbid_pkg::HIGH_VALUE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            bbid_pkg::REG_TILE_HEIGHT_LOG2:    tile_h_ff <= csr_wdata[bbid_pkg::TILE_LOG2_W-1:0];
            bbid_pkg::REG_TILE_WIDTH_LOG2:     tile_w_ff <= csr_wdata[bbid_pkg::TILE_LOG2_W-1:0];
            bbid_pkg::REG_SQUARE_CUT_VERTICAL: cut_v_ff  <= csr_wdata[0];
            bbid_pkg::REG_LOW_VALUE:           low_ff    <= csr_wdata;
            bbid_pkg::REG_HIGH_VALUE:          high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // input register; a bit is decoded once the queue has room for two words
   assign step      = in_valid_ff && (count_ff <= QCW'(QD - 2));
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_bit_ff <= req_code_bit;
      end
   end

   // ------------------------------------------------------------------------
   // region being decoded; at the root it comes from the live size registers
   assign bib_next = bib_ff + 1'b1;

   always_comb begin
      root.row = '0;
      root.col = '0;
      root.hl  = sat_log2(tile_h_ff);
      root.wl  = sat_log2(tile_w_ff);
      work = cur_ff;
      if (mode_ff == bbid_pkg::MODE_NODE && sp_ff == '0 && !first_ff) begin
         work = root;
      end
   end

   // halve the region: first half keeps the origin
   always_comb begin
      cut_vert = (work.hl < work.wl) || ((work.hl == work.wl) && cut_v_ff);
      split_a  = work;
      split_b  = work;
      if (cut_vert) begin
         split_a.wl  = work.wl - 1'b1;
         split_b.wl  = work.wl - 1'b1;
         split_b.col = work.col + (RW'(1) << split_a.wl);
      end else begin
         split_a.hl  = work.hl - 1'b1;
         split_b.hl  = work.hl - 1'b1;
         split_b.row = work.row + (RW'(1) << split_a.hl);
      end
   end

   // deepest pending sibling below the top entry
   always_comb begin
      found = 1'b0;
      tgt_m = '0;
      for (int m = 1; m < STACK_DEPTH; m++) begin
         if (stk_pf_ff[m] && (SPW'(m) < sp_ff)) begin
            found = 1'b1;
            tgt_m = SPW'(m);
         end
      end
      tgt_dec = tgt_m - 1'b1;
      tgt_idx = tgt_dec[IW-1:0];
   end

   // what this bit does
   always_comb begin
      fill_first = 1'b0;
      fill_c     = in_bit_ff;
      fin_has_c  = 1'b0;
      do_split   = 1'b0;
      to_colour  = 1'b0;
      unique case (mode_ff)
         bbid_pkg::MODE_SKIP: ;
         bbid_pkg::MODE_NODE: begin
            if (is_unit(work)) begin
               fill_first = 1'b1;
               fin_has_c  = 1'b1;
            end else if (in_bit_ff) begin
               to_colour = 1'b1;
            end else begin
               do_split = 1'b1;
            end
         end
         bbid_pkg::MODE_COLOUR: begin
            fill_first = 1'b1;
            fin_has_c  = 1'b1;
         end
         bbid_pkg::MODE_FLAG: begin
            if (in_bit_ff) begin
               fill_first = 1'b1;
               fill_c     = !colour_ff;
            end else begin
               do_split = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // after a fill: go to the sibling, or unwind to the deepest pending one
   assign to_sib   = first_ff && (sp_ff != '0);
   assign second   = to_sib && fin_has_c && is_unit(top_sib_ff);
   assign walk     = !to_sib || second;
   assign tile_end = fill_first && walk && !found;
   assign overflow = do_split && (sp_ff >= SPW'(STACK_DEPTH));
   assign push_idx = sp_ff[IW-1:0];

   // next decoder state
   always_comb begin
      mode_in    = mode_ff;
      cur_in     = cur_ff;
      first_in   = first_ff;
      sp_in      = sp_ff;
      bib_in     = bib_ff;
      top_sib_in = top_sib_ff;
      colour_in  = colour_ff;
      push_en    = 1'b0;
      if (step) begin
         bib_in = bib_next;
         if (mode_ff == bbid_pkg::MODE_SKIP) begin
            if (bib_next == '0) begin
               mode_in = bbid_pkg::MODE_NODE;
            end
         end else if (to_colour) begin
            mode_in = bbid_pkg::MODE_COLOUR;
            cur_in  = work;
         end else if (tile_end || overflow) begin
            sp_in    = '0;
            first_in = 1'b0;
            mode_in  = (bib_next != '0) ? bbid_pkg::MODE_SKIP : bbid_pkg::MODE_NODE;
         end else if (do_split) begin
            push_en    = 1'b1;
            top_sib_in = split_b;
            sp_in      = sp_ff + 1'b1;
            cur_in     = split_a;
            first_in   = 1'b1;
            mode_in    = bbid_pkg::MODE_NODE;
         end else if (fill_first) begin
            first_in = 1'b0;
            if (walk) begin
               cur_in  = stk_sib_ff[tgt_idx];
               sp_in   = tgt_m;
               mode_in = bbid_pkg::MODE_NODE;
            end else begin
               cur_in    = top_sib_ff;
               colour_in = fill_c;
               mode_in   = fin_has_c ? bbid_pkg::MODE_FLAG : bbid_pkg::MODE_NODE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bbid_pkg::MODE_NODE;
         first_ff <= 1'b0;
         sp_ff    <= '0;
         bib_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         first_ff <= first_in;
         sp_ff    <= sp_in;
         bib_ff   <= bib_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      top_sib_ff <= top_sib_in;
      colour_ff  <= colour_in;
   end

   // stack entry: sibling region and whether its parent was a first half
   always_ff @(posedge clock) begin
      if (push_en) begin
         stk_sib_ff[push_idx] <= split_b;
         stk_pf_ff[push_idx]  <= first_ff;
      end
   end

   // ------------------------------------------------------------------------
   // fill words produced by this bit
   always_comb begin
      res0 = make_fill(work, fill_c, low_ff, high_ff);
      res1 = make_fill(top_sib_ff, !in_bit_ff, low_ff, high_ff);
      res0.tile_done   = tile_end && !second;
      res0.last_of_run = !second;
      res1.tile_done   = tile_end;
      res1.last_of_run = 1'b1;
      n_res = 2'd0;
      if (step && fill_first) begin
         n_res = second ? 2'd2 : 2'd1;
      end
   end

   // ------------------------------------------------------------------------
   // result queue
   assign rsp_pop   = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rd_ptr_in = rd_ptr_ff + QPW'(rsp_pop);
   assign wr_ptr_in = wr_ptr_ff + QPW'(n_res);
   assign count_in  = count_ff + QCW'(n_res) - QCW'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         q_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign rsp_word             = q_ff[rd_ptr_ff];
   assign rsp_fill_row         = rsp_word.fill_row;
   assign rsp_fill_col         = rsp_word.fill_col;
   assign rsp_fill_height_log2 = rsp_word.fill_height_log2;
   assign rsp_fill_width_log2  = rsp_word.fill_width_log2;
   assign rsp_pixel_value      = rsp_word.pixel_value;
   assign rsp_tile_done        = rsp_word.tile_done;
   assign rsp_last_of_run      = rsp_word.last_of_run;

endmodule
